[design/gyds_pkg.sv]
// Shared types and constants for the grid y-derivative stencil.
`timescale 1ns / 1ps
package gyds_pkg;

  // Grid geometry and line buffer sizing
  localparam int MAX_ROW_LEN = 1024;
  localparam int COL_W       = $clog2(MAX_ROW_LEN);
  localparam int ROW_W       = 16;
  localparam int LEN_W       = 11;

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SPACING = 2'd2;
  localparam int CFG_DATA_W = 32;

  // Reset values of the configuration registers
  localparam logic [LEN_W-1:0] ROW_LENGTH_RST      = 11'd1024;
  localparam logic [ROW_W-1:0] ROW_COUNT_RST       = 16'd2;
  localparam logic [31:0]      INVERSE_SPACING_RST = 32'd42950;

  // Input item
  typedef struct packed {
    logic signed [31:0] sample;
    logic [23:0]        map_scale;
    logic               is_missing;
  } in_t;

  // Result item
  typedef struct packed {
    logic signed [63:0] derivative;
    logic               result_missing;
    logic [15:0]        out_row;
    logic [9:0]         out_col;
    logic               last;
  } out_t;

  // One grid value with its missing flag
  typedef struct packed {
    logic               miss;
    logic signed [31:0] value;
  } point_t;

  // One line buffer word: older row, newer row, newer row's scale
  typedef struct packed {
    point_t      low;
    point_t      up;
    logic [23:0] scale;
  } line_word_t;

  localparam int LINE_W = $bits(line_word_t);

  // Work for the back end: first result (a) and optional top-row result (b)
  typedef struct packed {
    point_t             cur;
    point_t             a_lo;
    point_t             b_lo;
    logic [24:0]        s_a;
    logic [24:0]        s_b;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               two;
  } job_t;

  // Front to queue push
  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

endpackage

[design/grid_y_derivative_stencil_top.sv]
// Top level of the grid y-derivative stencil: config registers and units.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------
//  in      | in_valid / in_ready    | in_item   (sample, map_scale, is_missing)
//  out     | out_valid / out_ready  | out_item  (derivative .. last)
//  cfg     | cfg_we                 | cfg_index, cfg_data
//
// The front takes one item per cycle while the 4-entry job queue has room.
// Each result passes through the back sequencer, which pops a job only when idle,
// on the one shared 32x32 multiplier used three times per result: one result for
// an interior item, two on the top row, none on the first row.
// Reset clears counters, queue and sequencer; line buffers are not cleared.
// Either side may stall; the queue and output register hold items meanwhile.
`timescale 1ns / 1ps
module grid_y_derivative_stencil_top import gyds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LEN_W-1:0]  row_length;
  logic [ROW_W-1:0]  row_count;
  logic [31:0]       inverse_spacing;
  push_t             q_push;
  job_t              q_head;
  logic [QCNT_W-1:0] q_count;
  logic              pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length      <= ROW_LENGTH_RST;
      row_count       <= ROW_COUNT_RST;
      inverse_spacing <= INVERSE_SPACING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_LENGTH:      row_length      <= cfg_data[LEN_W-1:0];
        REG_ROW_COUNT:       row_count       <= cfg_data[ROW_W-1:0];
        REG_INVERSE_SPACING: inverse_spacing <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  gyds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .row_length (row_length),
    .row_count  (row_count),
    .q_count    (q_count),
    .q_push     (q_push)
  );

  gyds_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (pop),
    .head   (q_head),
    .count  (q_count)
  );

  gyds_back u_back (
    .clk             (clk),
    .rst             (rst),
    .inverse_spacing (inverse_spacing),
    .q_empty         (q_count == '0),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item)
  );

endmodule

[design/gyds_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gyds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/gyds_front.sv]
// Front end: raster counters, line buffer RAM and stencil job building.
`timescale 1ns / 1ps
module gyds_front import gyds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_item,
  input  logic [LEN_W-1:0]  row_length,
  input  logic [ROW_W-1:0]  row_count,
  input  logic [QCNT_W-1:0] q_count,
  output push_t             q_push
);

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             accept;
  logic [LEN_W-1:0] len_eff;
  logic [ROW_W-1:0] n_eff;
  logic             col_wrap;
  logic             row_wrap;

  // Stage 1 registers (RAM read in flight)
  logic             s1_valid;
  point_t           s1_cur;
  logic [23:0]      s1_sc;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_bottom;
  logic             s1_has;
  logic             s1_top;

  logic [LINE_W-1:0] ram_rdata;
  line_word_t        rd;
  line_word_t        wr;
  logic [24:0]       s_sum;

  // Room check counts the item still in stage 1
  assign in_ready = (q_count + QCNT_W'(s1_valid)) < QCNT_W'(QDEPTH);
  assign accept   = in_valid && in_ready;

  // Clamped geometry and wrap decisions
  always_comb begin
    if (row_length < LEN_W'(2)) begin
      len_eff = LEN_W'(2);
    end else if (row_length > LEN_W'(MAX_ROW_LEN)) begin
      len_eff = LEN_W'(MAX_ROW_LEN);
    end else begin
      len_eff = row_length;
    end
    n_eff    = (row_count < ROW_W'(2)) ? ROW_W'(2) : row_count;
    col_wrap = ({1'b0, col} + LEN_W'(1)) >= len_eff;
    row_wrap = ({1'b0, row} + 17'd1) >= {1'b0, n_eff};
  end

  // Raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (col_wrap) begin
          col <= '0;
          row <= row_wrap ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  // Capture item and its classification
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur.miss  <= in_item.is_missing;
      s1_cur.value <= in_item.sample;
      s1_sc        <= in_item.map_scale;
      s1_col       <= col;
      s1_row       <= row;
      s1_bottom    <= (row == ROW_W'(1));
      s1_has       <= (row != '0);
      s1_top       <= (row == n_eff - ROW_W'(1));
    end
  end

  // Two value rows plus one scale row, addressed by column
  gyds_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_ROW_LEN)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (wr),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // Shift the column up one row and build the job
  always_comb begin
    rd       = line_word_t'(ram_rdata);
    s_sum    = {1'b0, s1_sc} + {1'b0, rd.scale};
    wr.low   = rd.up;
    wr.up    = s1_cur;
    wr.scale = s1_sc;

    q_push.push     = s1_valid && s1_has;
    q_push.job.cur  = s1_cur;
    q_push.job.a_lo = s1_bottom ? rd.up : rd.low;
    q_push.job.b_lo = rd.up;
    q_push.job.s_a  = s1_bottom ? s_sum : {1'b0, rd.scale};
    q_push.job.s_b  = s_sum;
    q_push.job.row  = s1_row;
    q_push.job.col  = s1_col;
    q_push.job.two  = s1_top;
  end

endmodule

[design/gyds_fifo.sv]
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
module gyds_fifo import gyds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  push_t             q_push,
  input  logic              pop,
  output job_t              head,
  output logic [QCNT_W-1:0] count
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;

  assign head = entries[rptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (q_push.push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(q_push.push) - QCNT_W'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (q_push.push) begin
      entries[wptr] <= q_push.job;
    end
  end

endmodule

[design/gyds_back.sv]
// Back end: difference, scale and rounding on one shared multiplier.
`timescale 1ns / 1ps
module gyds_back import gyds_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] inverse_spacing,
  input  logic        q_empty,
  input  job_t        q_head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_item
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIFF = 4'd1;
  localparam logic [3:0] ST_ABS  = 4'd2;
  localparam logic [3:0] ST_M1   = 4'd3;
  localparam logic [3:0] ST_M2   = 4'd4;
  localparam logic [3:0] ST_M3   = 4'd5;
  localparam logic [3:0] ST_SUM  = 4'd6;
  localparam logic [3:0] ST_NEG  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0]  state;
  logic        second;
  job_t        job;

  // Working registers
  logic signed [32:0] diff;
  logic               miss;
  logic [24:0]        s_cur;
  logic [ROW_W-1:0]   row_cur;
  logic               neg;
  logic [31:0]        mag;
  logic [56:0]        prod_a;
  logic [63:0]        p_lo;
  logic [56:0]        p_hi;
  logic [60:0]        r_mag;
  logic [63:0]        res;

  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] mul_p;
  point_t      hi_pt;
  logic        load_out;

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign load_out = (state == ST_FIN) && (!out_valid || out_ready);
  assign hi_pt    = job.cur;

  // Shared multiplier operand select
  always_comb begin
    unique case (state)
      ST_M1: begin
        mul_x = mag;
        mul_y = {7'd0, s_cur};
      end
      ST_M2: begin
        mul_x = prod_a[31:0];
        mul_y = inverse_spacing;
      end
      default: begin
        mul_x = {7'd0, prod_a[56:32]};
        mul_y = inverse_spacing;
      end
    endcase
    mul_p = 64'(mul_x) * 64'(mul_y);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      second    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            second <= 1'b0;
            state  <= ST_DIFF;
          end
        end
        ST_DIFF: state <= ST_ABS;
        ST_ABS:  state <= ST_M1;
        ST_M1:   state <= ST_M2;
        ST_M2:   state <= ST_M3;
        ST_M3:   state <= ST_SUM;
        ST_SUM:  state <= ST_NEG;
        ST_NEG:  state <= ST_FIN;
        ST_FIN: begin
          if (load_out) begin
            if (job.two && !second) begin
              second <= 1'b1;
              state  <= ST_DIFF;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_head;
    end
    if (state == ST_DIFF) begin
      if (second) begin
        diff    <= {hi_pt.value[31], hi_pt.value} - {job.b_lo.value[31], job.b_lo.value};
        miss    <= hi_pt.miss || job.b_lo.miss;
        s_cur   <= job.s_b;
        row_cur <= job.row;
      end else begin
        diff    <= {hi_pt.value[31], hi_pt.value} - {job.a_lo.value[31], job.a_lo.value};
        miss    <= hi_pt.miss || job.a_lo.miss;
        s_cur   <= job.s_a;
        row_cur <= job.row - ROW_W'(1);
      end
    end
    if (state == ST_ABS) begin
      neg <= diff[32];
      mag <= diff[32] ? 32'(-diff) : diff[31:0];
    end
    if (state == ST_M1) begin
      prod_a <= mul_p[56:0];
    end
    if (state == ST_M2) begin
      p_lo <= mul_p;
    end
    if (state == ST_M3) begin
      p_hi <= mul_p[56:0];
    end
    // Drop 29 fraction bits, round half away from zero on the magnitude
    if (state == ST_SUM) begin
      r_mag <= {1'b0, p_hi, 3'b000} + {26'd0, p_lo[63:29]} + {60'd0, p_lo[28]};
    end
    if (state == ST_NEG) begin
      res <= neg ? (64'd0 - {3'd0, r_mag}) : {3'd0, r_mag};
    end
    if (load_out) begin
      out_item.derivative     <= miss ? '0 : res;
      out_item.result_missing <= miss;
      out_item.out_row        <= row_cur;
      out_item.out_col        <= job.col;
      out_item.last           <= second || !job.two;
    end
  end

endmodule

[design/gyds_checker.sv]
// Port-level checks for the grid y-derivative stencil, bound to the top.
`timescale 1ns / 1ps
module gyds_checker import gyds_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_item
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // Missing stencil gives a zero derivative
  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result_missing |-> out_item.derivative == 64'sd0)
    else $error("missing result with nonzero derivative");

  // Magnitude stays below 2^61, so the top bits are pure sign
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.derivative[63:61] == 3'b000) ||
                  (out_item.derivative[63:61] == 3'b111))
    else $error("derivative out of range");

endmodule

bind grid_y_derivative_stencil_top gyds_checker u_gyds_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

[bench/grid_y_derivative_stencil_top_test.sv]
// Self-checking bench for the grid y-derivative stencil: streamed grids against a local predictor.
`timescale 1ns / 1ps
module grid_y_derivative_stencil_top_test;
  import gyds_pkg::*;

  localparam int RANDOM_ITEMS  = 700;
  localparam int SETTLE_CYCLES = 40;     // a top-row item keeps the back end busy for two results
  localparam int IDLE_LIMIT    = 4000;   // well above the longest receiver hold-off
  localparam int PRESSURE_HOLD = 400;
  localparam int PRINT_LIMIT   = 40;
  localparam logic [31:0] SAMPLE_MIN = 32'h8000_0000;
  localparam logic [31:0] SAMPLE_MAX = 32'h7FFF_FFFF;
  localparam logic [23:0] SCALE_MAX  = 24'hFF_FFFF;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ROW_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  grid_y_derivative_stencil_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench state
  in_t  pending_points[$];
  out_t expected_derivs[$];
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_len       = 0;
  int   hold_left      = 0;
  int   mismatches     = 0;
  int   idle_cycles    = 0;
  int   random_items   = 0;
  bit   in_took        = 1'b0;

  // Predictor copy of the registers and line buffers
  logic [LEN_W-1:0] cfg_row_length  = ROW_LENGTH_RST;
  logic [ROW_W-1:0] cfg_row_count   = ROW_COUNT_RST;
  logic [31:0]      cfg_inv_spacing = INVERSE_SPACING_RST;
  point_t           older_row [MAX_ROW_LEN];
  point_t           newer_row [MAX_ROW_LEN];
  logic [23:0]      prev_scale [MAX_ROW_LEN];
  int               col_pos = 0;
  int               row_pos = 0;

  // |diff| * s * inv, Q27.69 down to Q27.40, rounded half away from zero
  function automatic logic [63:0] scale_diff(longint diff, logic [24:0] s);
    logic [95:0] mag;
    logic [95:0] prod;
    logic [66:0] q;
    logic [63:0] r;
    mag  = (diff < 0) ? 96'(-diff) : 96'(diff);
    prod = mag * 96'(s) * 96'(cfg_inv_spacing);
    q    = prod[95:29] + 67'(prod[28]);
    if (q > 67'h7FFF_FFFF_FFFF_FFFF) begin
      r = (diff < 0) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      r = (diff < 0) ? -q[63:0] : q[63:0];
    end
    return r;
  endfunction

  function automatic out_t stencil_result(point_t upper, point_t lower, logic [24:0] s,
                                          int row, int col);
    out_t   res;
    longint diff;
    diff               = longint'($signed(upper.value)) - longint'($signed(lower.value));
    res.result_missing = upper.miss | lower.miss;
    res.derivative     = res.result_missing ? 64'd0 : scale_diff(diff, s);
    res.out_row        = 16'(row);
    res.out_col        = 10'(col);
    res.last           = 1'b0;
    return res;
  endfunction

  // One accepted grid point: queue the derivatives it completes, shift the lines
  task automatic advance_stencil(in_t pt);
    int          len;
    int          rows;
    int          c;
    int          r;
    point_t      cur;
    point_t      below1;
    point_t      below2;
    logic [23:0] sp;
    logic [24:0] pair_scale;
    out_t        first;
    out_t        second;
    len  = cfg_row_length;
    if (len < 2) len = 2;
    if (len > MAX_ROW_LEN) len = MAX_ROW_LEN;
    rows = cfg_row_count;
    if (rows < 2) rows = 2;
    c = col_pos;
    r = row_pos;
    cur.miss   = pt.is_missing;
    cur.value  = pt.sample;
    below2     = older_row[c];
    below1     = newer_row[c];
    sp         = prev_scale[c];
    pair_scale = 25'(pt.map_scale) + 25'(sp);
    if (r >= 1) begin
      if (r == 1) begin
        first = stencil_result(cur, below1, pair_scale, 0, c);
      end else begin
        first = stencil_result(cur, below2, 25'(sp), r - 1, c);
      end
      if (r == rows - 1) begin
        second      = stencil_result(cur, below1, pair_scale, r, c);
        second.last = 1'b1;
        expected_derivs.push_back(first);
        expected_derivs.push_back(second);
      end else begin
        first.last = 1'b1;
        expected_derivs.push_back(first);
      end
    end
    older_row[c]  = below1;
    newer_row[c]  = cur;
    prev_scale[c] = pt.map_scale;
    if (c + 1 >= len) begin
      col_pos = 0;
      row_pos = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // Sender: next item at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item  <= pending_points.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor, checker and watchdog
  always @(posedge clk) begin
    out_t want;
    bit   out_took;
    in_took  = in_valid && in_ready && !rst;
    out_took = out_valid && out_ready && !rst;
    if (out_took) begin
      if (expected_derivs.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d col %0d",
                                  out_item.out_row, out_item.out_col));
      end else begin
        want = expected_derivs.pop_front();
        if (out_item.derivative !== want.derivative)
          report_mismatch($sformatf("derivative %h, want %h (row %0d col %0d)",
                                    out_item.derivative, want.derivative,
                                    want.out_row, want.out_col));
        if (out_item.result_missing !== want.result_missing)
          report_mismatch($sformatf("result_missing %b, want %b (row %0d col %0d)",
                                    out_item.result_missing, want.result_missing,
                                    want.out_row, want.out_col));
        if (out_item.out_row !== want.out_row)
          report_mismatch($sformatf("out_row %0d, want %0d", out_item.out_row, want.out_row));
        if (out_item.out_col !== want.out_col)
          report_mismatch($sformatf("out_col %0d, want %0d", out_item.out_col, want.out_col));
        if (out_item.last !== want.last)
          report_mismatch($sformatf("last %b, want %b (row %0d col %0d)",
                                    out_item.last, want.last, want.out_row, want.out_col));
      end
    end
    if (in_took) advance_stencil(in_item);
    if (rst || in_took || out_took) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_derivs.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic in_t grid_point(logic [31:0] sample, logic [23:0] scale, logic miss);
    in_t p;
    p.sample     = sample;
    p.map_scale  = scale;
    p.is_missing = miss;
    return p;
  endfunction

  function automatic in_t random_point();
    in_t p;
    case ($urandom_range(9))
      0:       p.sample = SAMPLE_MIN;
      1:       p.sample = SAMPLE_MAX;
      2, 3:    p.sample = 32'($urandom_range(512)) - 32'd256;
      default: p.sample = $urandom;
    endcase
    case ($urandom_range(7))
      0:       p.map_scale = '0;
      1:       p.map_scale = SCALE_MAX;
      default: p.map_scale = 24'($urandom);
    endcase
    p.is_missing = ($urandom_range(11) == 0);
    return p;
  endfunction

  task automatic push_random_points(int count);
    for (int i = 0; i < count; i++) begin
      pending_points.push_back(random_point());
      random_items++;
    end
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
  endtask

  // Wait until every item is in and every result out, then let the back end settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_points.size() != 0 || in_valid || expected_derivs.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Called at a falling edge while the block is idle
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_ROW_LENGTH:      cfg_row_length  = value[LEN_W-1:0];
      REG_ROW_COUNT:       cfg_row_count   = value[ROW_W-1:0];
      REG_INVERSE_SPACING: cfg_inv_spacing = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_grid(int len, int rows, logic [31:0] inv);
    write_register(REG_ROW_LENGTH, len);
    write_register(REG_ROW_COUNT, rows);
    write_register(REG_INVERSE_SPACING, inv);
  endtask

  // Start a tall grid, then cut row_count below the current row mid-grid
  task automatic run_shrunk_grid(int len, int tall_rows, int full_rows, int cut_rows);
    set_grid(len, tall_rows, cfg_inv_spacing);
    push_random_points(full_rows * len);
    wait_drained();
    write_register(REG_ROW_COUNT, cut_rows);
    push_random_points(len);
    wait_drained();
  endtask

  initial begin
    int          phase;
    int          len;
    int          rows;
    int          tall;
    int          full;
    logic [31:0] inv;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset geometry: full 1024-point bottom row, then cut the second row short
    set_idling(1);
    push_random_points(MAX_ROW_LEN + 32);
    wait_drained();
    write_register(REG_ROW_LENGTH, 33);
    push_random_points(1);
    wait_drained();

    // Directed 4x4 grid: field extremes, missing points, all three stencils
    set_idling(0);
    set_grid(4, 4, 32'hFFFF_FFFF);
    pending_points.push_back(grid_point(SAMPLE_MIN, SCALE_MAX, 1'b0));
    pending_points.push_back(grid_point(SAMPLE_MAX, SCALE_MAX, 1'b0));
    pending_points.push_back(grid_point(32'd0, 24'd0, 1'b1));
    pending_points.push_back(grid_point(32'd1, 24'd1, 1'b0));
    pending_points.push_back(grid_point(SAMPLE_MAX, SCALE_MAX, 1'b0));
    pending_points.push_back(grid_point(SAMPLE_MIN, SCALE_MAX, 1'b0));
    pending_points.push_back(grid_point(32'd5, 24'h80_0000, 1'b0));
    // missing centre point: centred result must ignore it
    pending_points.push_back(grid_point(-32'sd1, 24'h12_3456, 1'b1));
    pending_points.push_back(grid_point(SAMPLE_MIN, SCALE_MAX, 1'b0));
    pending_points.push_back(grid_point(SAMPLE_MAX, SCALE_MAX, 1'b0));
    pending_points.push_back(grid_point(-32'sd7, 24'd0, 1'b0));
    pending_points.push_back(grid_point(32'd3, SCALE_MAX, 1'b0));
    pending_points.push_back(grid_point(SAMPLE_MAX, SCALE_MAX, 1'b1));
    pending_points.push_back(grid_point(SAMPLE_MIN, SCALE_MAX, 1'b0));
    pending_points.push_back(grid_point(32'd0, 24'd1, 1'b0));
    pending_points.push_back(grid_point(32'd100, 24'hAB_CDEF, 1'b0));
    wait_drained();

    // Exact rounding ties, both signs
    set_idling(2);
    set_grid(2, 3, 32'h1000_0000);
    pending_points.push_back(grid_point(32'd0, 24'd0, 1'b0));
    pending_points.push_back(grid_point(32'd0, 24'd0, 1'b0));
    pending_points.push_back(grid_point(32'd1, 24'd1, 1'b0));
    pending_points.push_back(grid_point(-32'sd1, 24'd1, 1'b0));
    pending_points.push_back(grid_point(32'd1, 24'd0, 1'b0));
    pending_points.push_back(grid_point(-32'sd1, 24'd0, 1'b0));
    wait_drained();

    // Largest row_count, then cut below the current row
    set_idling(3);
    run_shrunk_grid(3, 65535, 4, 3);

    // Random grids
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      set_idling(phase);
      case ($urandom_range(5))
        0:       inv = 32'd0;
        1:       inv = 32'hFFFF_FFFF;
        2:       inv = $urandom_range(1, 100000);
        default: inv = $urandom;
      endcase
      if (phase == 0) begin
        // Long receiver hold-off while the sender keeps offering: fills the job queue
        set_grid(8, 6, inv);
        push_random_points(48);
        @(posedge clk);
        hold_len = PRESSURE_HOLD;
        wait_drained();
      end else if ($urandom_range(4) == 0) begin
        tall = $urandom_range(6, 12);
        full = $urandom_range(3, tall - 2);
        write_register(REG_INVERSE_SPACING, inv);
        run_shrunk_grid($urandom_range(2, 10), tall, full, $urandom_range(2, full));
      end else begin
        len  = ($urandom_range(3) == 0) ? $urandom_range(13, 64) : $urandom_range(2, 12);
        rows = $urandom_range(2, 8);
        set_grid(len, rows, inv);
        push_random_points(len * rows * $urandom_range(1, 3));
        wait_drained();
      end
      phase++;
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
